FILE: rtl/fyrs_pkg.sv
// fyrs_pkg: shared types, codes and widths of the range shuffle core
`timescale 1ns / 1ps
package fyrs_pkg;

  // default number of store entries
  localparam int STORE_DEPTH_DEF = 52;

  // payload field widths
  localparam int CMD_W   = 1;
  localparam int WORD_W  = 31;
  localparam int FIELD_W = 6;

  // configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_SHUFFLE = 1'b0;
  localparam cmd_t CMD_RESTORE = 1'b1;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_LOW_INDEX  = 1'b0;
  localparam reg_idx_t REG_HIGH_INDEX = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_RD_TOP,
    S_RD_OTH,
    S_RD_LOW,
    S_WR_TOP,
    S_WR_OTH,
    S_EMIT1,
    S_EMIT2
  } fyrs_state_t;

endpackage

FILE: rtl/fyrs_if.sv
// fyrs_if: valid/ready channel interfaces for step items and results
`timescale 1ns / 1ps
interface fyrs_in_if import fyrs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [WORD_W-1:0]   random_word;

  modport source (output valid, output command, output random_word, input ready);
  modport sink   (input valid, input command, input random_word, output ready);
endinterface

interface fyrs_out_if import fyrs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  position;
  logic [FIELD_W-1:0]  entry_value;
  logic                last;

  modport source (output valid, output position, output entry_value, output last,
                  input ready);
  modport sink   (input valid, input position, input entry_value, input last,
                  output ready);
endinterface

FILE: rtl/fisher_yates_range_shuffle_core.sv
// fisher_yates_range_shuffle_core: range shuffle engine over a permutation store
`timescale 1ns / 1ps
// Durstenfeld shuffle over the store positions low_index..high_index. The store
// comes out of reset (and out of a restore command) in identity order; a valid
// flag per entry makes an entry that was never written read as its own index,
// so restore and reset take effect with no clearing pass.
// Each shuffle-step item brings one random word; the step reduces it modulo
// the live span (top - low + 1) with a restoring bit-serial remainder, one bit
// a cycle over the 31 bits, then swaps entries top and low + remainder through
// the store, one access a cycle: three reads (top, other, low), then two writes.
// The step transfers one result for position top, plus a second one flagged
// last for position low when the pass completes. After its transfer a step
// runs the remainder loop (S_DIV), the store accesses (S_RD_TOP to S_WR_OTH),
// then loads the first result (S_EMIT1) and the second (S_EMIT2), each once the
// output register is free; the next item is taken in S_IDLE after the last
// load. A restore or an empty-range step is handled at its transfer without
// leaving S_IDLE. The input is taken only between steps; a finished result may
// still wait in the output register while the next step is taken.
// All reads of a step finish before its writes, so no forwarding is needed.
module fisher_yates_range_shuffle_core
  import fyrs_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  fyrs_in_if.sink            in_ch,
  fyrs_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  // store address width, span width, and a roomy width for index compares
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int SW  = AW + 1;
  localparam int IW  = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
  localparam int CW  = $clog2(WORD_W);

  // saturate a register index to the last store position
  function automatic logic [AW-1:0] clamp_idx(input logic [FIELD_W-1:0] v);
    logic [IW-1:0] ext;
    ext = IW'(v);
    if (ext >= IW'(STORE_DEPTH)) begin
      return AW'(STORE_DEPTH - 1);
    end
    return ext[AW-1:0];
  endfunction

  // configuration registers
  logic [FIELD_W-1:0] low_index_r;
  logic [FIELD_W-1:0] high_index_r;

  // control state
  fyrs_state_t        state_r, state_nxt;
  logic               pass_active_r;
  logic [AW-1:0]      top_r;
  logic [STORE_DEPTH-1:0] valid_r;
  logic               has2_r;

  // step datapath
  logic [AW-1:0]      low_r;
  logic [AW-1:0]      pos_r;
  logic [AW-1:0]      other_r;
  logic [SW-1:0]      span_r;
  logic [SW-1:0]      rem_r;
  logic [WORD_W-1:0]  word_r;
  logic [CW-1:0]      cnt_r;
  logic [AW-1:0]      val_top_r;
  logic [AW-1:0]      val_oth_r;
  logic [AW-1:0]      val_low_r;

  // store access
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [AW-1:0]      ram_q;
  logic               rd_valid_r;
  logic [AW-1:0]      rd_addr_r;
  logic [AW-1:0]      rd_data;

  // output register
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_pos_r;
  logic [FIELD_W-1:0] out_val_r;
  logic               out_last_r;
  logic               out_load;

  // step set-up, evaluated at the input transfer
  logic               in_xfer;
  logic [AW-1:0]      low_c;
  logic [AW-1:0]      high_c;
  logic               pass_still;
  logic [AW-1:0]      start_top;
  logic               range_empty;

  // remainder step
  logic [SW:0]        rem_shift;
  logic [SW-1:0]      rem_next;

  // result values
  logic [AW-1:0]      top_dec;
  logic [AW-1:0]      res2_val;
  logic [IW-1:0]      pos_ext;
  logic [IW-1:0]      val_ext;

  fyrs_ram #(
    .WIDTH (AW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // an entry never written since restore reads as its own position
  assign rd_data = rd_valid_r ? ram_q : rd_addr_r;

  // apb side: writes complete in the access phase, no wait states
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_LOW_INDEX:  prdata = APB_DW'(low_index_r);
      REG_HIGH_INDEX: prdata = APB_DW'(high_index_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_index_r  <= '0;
      high_index_r <= FIELD_W'(51);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_LOW_INDEX:  low_index_r  <= pwdata[FIELD_W-1:0];
        REG_HIGH_INDEX: high_index_r <= pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // step set-up: a running pass continues only while top is above the live low
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign low_c       = clamp_idx(low_index_r);
  assign high_c      = clamp_idx(high_index_r);
  assign pass_still  = pass_active_r && (top_r > low_c);
  assign start_top   = pass_still ? top_r : high_c;
  assign range_empty = !pass_still && (high_c <= low_c);

  // restoring remainder, one word bit a cycle, msb first
  assign rem_shift = {rem_r, word_r[WORD_W-1]};
  assign rem_next  = (rem_shift >= {1'b0, span_r}) ? SW'(rem_shift - {1'b0, span_r})
                                                   : rem_shift[SW-1:0];

  assign top_dec  = top_r - AW'(1);
  // low after the swap holds the old top entry only when low was the partner
  assign res2_val = (other_r == low_r) ? val_top_r : val_low_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_ch.command == CMD_SHUFFLE && !range_empty) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_RD_TOP;
        end
      end
      S_RD_TOP: state_nxt = S_RD_OTH;
      S_RD_OTH: state_nxt = S_RD_LOW;
      S_RD_LOW: state_nxt = S_WR_TOP;
      S_WR_TOP: state_nxt = S_WR_OTH;
      S_WR_OTH: state_nxt = S_EMIT1;
      S_EMIT1: begin
        if (out_load) begin
          state_nxt = has2_r ? S_EMIT2 : S_IDLE;
        end
      end
      S_EMIT2: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = pos_r;
    ram_wdata   = val_oth_r;
    ram_raddr   = pos_r;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ch.ready = 1'b1;
      S_RD_TOP: ram_raddr = pos_r;
      S_RD_OTH: ram_raddr = other_r;
      S_RD_LOW: ram_raddr = low_r;
      S_WR_TOP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_oth_r;
      end
      S_WR_OTH: begin
        ram_we    = 1'b1;
        ram_waddr = other_r;
        ram_wdata = val_top_r;
      end
      S_EMIT1, S_EMIT2: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pass_active_r <= 1'b0;
      top_r         <= '0;
      valid_r       <= '0;
      has2_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (in_xfer) begin
        if (in_ch.command == CMD_RESTORE) begin
          pass_active_r <= 1'b0;
          top_r         <= '0;
          valid_r       <= '0;
        end else if (range_empty) begin
          pass_active_r <= 1'b0;
        end else begin
          pass_active_r <= 1'b1;
          top_r         <= start_top;
        end
      end

      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end

      // end of swap: retire top, close the pass when it meets low
      if (state_r == S_WR_OTH) begin
        top_r         <= top_dec;
        has2_r        <= (top_dec == low_r);
        pass_active_r <= (top_dec != low_r);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_valid_r <= valid_r[ram_raddr];
    rd_addr_r  <= ram_raddr;

    if (in_xfer) begin
      low_r  <= low_c;
      pos_r  <= start_top;
      span_r <= SW'(start_top) - SW'(low_c) + SW'(1);
      word_r <= in_ch.random_word;
      rem_r  <= '0;
      cnt_r  <= CW'(WORD_W - 1);
    end

    if (state_r == S_DIV) begin
      rem_r  <= rem_next;
      word_r <= word_r << 1;
      cnt_r  <= cnt_r - CW'(1);
      if (cnt_r == '0) begin
        other_r <= AW'(SW'(low_r) + rem_next);
      end
    end

    unique case (state_r)
      S_RD_OTH: val_top_r <= rd_data;
      S_RD_LOW: val_oth_r <= rd_data;
      S_WR_TOP: val_low_r <= rd_data;
      default: ;
    endcase

    if (out_load) begin
      out_pos_r  <= pos_ext[FIELD_W-1:0];
      out_val_r  <= val_ext[FIELD_W-1:0];
      out_last_r <= (state_r == S_EMIT2);
    end
  end

  // result selection, widened so that narrow stores zero-extend
  always_comb begin
    if (state_r == S_EMIT2) begin
      pos_ext = IW'(low_r);
      val_ext = IW'(res2_val);
    end else begin
      pos_ext = IW'(pos_r);
      val_ext = IW'(val_oth_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.entry_value = out_val_r;
  assign out_ch.last        = out_last_r;

  // remainder stays reduced below the span throughout the loop
  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < span_r)
    else $error("remainder not below span");

  // swap partner lies within the pass range
  a_partner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR_OTH |-> (other_r >= low_r) && (other_r <= pos_r))
    else $error("swap partner out of range");

  // restore leaves identity order and no pass
  a_restore_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_ch.command == CMD_RESTORE |=> !pass_active_r && valid_r == '0)
    else $error("restore did not clear state");

  // output register never overwritten while holding an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_ch.ready)
    else $error("result overwritten");

endmodule

FILE: rtl/fyrs_ram.sv
// fyrs_ram: generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module fyrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
